// File: design/welch_t_statistic_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Welch t statistic block
// Define ASSERT_OFF to compile the checks away.
// ----------------------------------------------------------------------------
`ifndef WELCH_T_STATISTIC_MACROS_SVH
`define WELCH_T_STATISTIC_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every rising edge outside reset
`define WTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising edge, reset included
`define WTS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WTS_ASSERT(lbl, prop, msg)
`define WTS_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Widths, codes and controller/datapath types of the Welch t statistic block.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int SMP_W       = 24;
  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W       = 35;
  localparam int SQ_W        = 58;
  localparam int VAL_SQ_W    = 2 * SMP_W - 1;
  localparam int WW          = 128;
  localparam int HW          = 64;
  localparam int T_W         = 32;
  localparam int DF_W        = 26;
  localparam int STATUS_W    = 2;
  localparam int V_SHIFT     = 24;
  localparam int T_SHIFT     = 28;
  localparam int DF_SHIFT    = 16;
  localparam int NORM_BITS   = 31;
  localparam int DIV_CNT_W   = $clog2(WW + 1);
  localparam int SQR_CNT_W   = $clog2(HW + 1);

  typedef enum logic [STATUS_W-1:0] {
    RES_OK    = 2'd0,
    RES_SMALL = 2'd1,
    RES_ZERO  = 2'd2
  } res_e;

  typedef enum logic [2:0] {
    S_ACC,
    S_CHECK,
    S_LOAD,
    S_RUN,
    S_STORE,
    S_VCHK,
    S_FINISH
  } ctrl_state_e;

  typedef enum logic [4:0] {
    ST_NQ0, ST_SS0, ST_DA0, ST_DB0, ST_V0,
    ST_NQ1, ST_SS1, ST_DA1, ST_DB1, ST_V1,
    ST_SQRT, ST_P1, ST_P0, ST_NN, ST_NSE, ST_T,
    ST_NORM, ST_AB2, ST_MM, ST_NM, ST_A2, ST_A2M, ST_B2, ST_B2M, ST_DF
  } step_e;

  typedef enum logic [1:0] {
    U_MUL,
    U_DIV,
    U_SQRT,
    U_NORM
  } unit_e;

  typedef struct packed {
    logic  acc;
    logic  load;
    logic  run;
    logic  store;
    logic  publish;
    step_e step;
    res_e  res;
    logic  with_df;
  } wts_cmd_t;

  typedef struct packed {
    logic small_grp;
    logic v_zero;
    logic unit_done;
    logic out_full;
    logic report_df;
  } wts_stat_t;

endpackage

// File: design/wts_smp_if.sv
// ----------------------------------------------------------------------------
// wts_smp_if
// Sample channel: one sample with its group flag and end-of-row mark.
// ----------------------------------------------------------------------------
interface wts_smp_if;
  import wts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample_value;
  logic                    group_flag;
  logic                    last_sample;

  modport source (output valid, sample_value, group_flag, last_sample, input ready);
  modport sink   (input valid, sample_value, group_flag, last_sample, output ready);
endinterface

// File: design/wts_res_if.sv
// ----------------------------------------------------------------------------
// wts_res_if
// Result channel: t statistic, degrees of freedom and status of one row.
// ----------------------------------------------------------------------------
interface wts_res_if;
  import wts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [T_W-1:0]   t_stat;
  logic [DF_W-1:0]         welch_df;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, t_stat, welch_df, status, input ready);
  modport sink   (input valid, t_stat, welch_df, status, output ready);
endinterface

// File: design/wts_div.sv
// ----------------------------------------------------------------------------
// wts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "welch_t_statistic_macros.svh"

module wts_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [wts_pkg::WW-1:0] num_i,
  input  logic [wts_pkg::WW-1:0] den_i,
  output logic                   done_o,
  output logic [wts_pkg::WW-1:0] quo_o
);
  import wts_pkg::*;

  logic [WW-1:0]        rem_q, rem_d;
  logic [WW-1:0]        quo_q, quo_d;
  logic [WW-1:0]        den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WW:0]          r2, diff;
  logic                 ge;

  always_comb begin
    r2    = {rem_q, quo_q[WW-1]};
    diff  = r2 - {1'b0, den_q};
    ge    = (r2 >= {1'b0, den_q});
    rem_d = ge ? diff[WW-1:0] : r2[WW-1:0];
    quo_d = {quo_q[WW-2:0], ge};
    cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= DIV_CNT_W'(WW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quo_o  = quo_q;

  `WTS_ASSERT(a_div_done_holds, (!start_i && done_o) |=> done_o, "divider left done without start")
endmodule

// File: design/wts_ctrl.sv
// ----------------------------------------------------------------------------
// wts_ctrl
// Controller: takes samples, then walks the arithmetic steps of a row.
// ----------------------------------------------------------------------------
`include "welch_t_statistic_macros.svh"

module wts_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               smp_valid_i,
  input  logic               smp_last_i,
  output logic               smp_ready_o,
  input  wts_pkg::wts_stat_t stat_i,
  output wts_pkg::wts_cmd_t  cmd_o
);
  import wts_pkg::*;

  ctrl_state_e state_q, state_d;
  step_e       step_q, step_d;
  res_e        res_q, res_d;
  logic        with_df_q, with_df_d;
  logic        acc;

  assign smp_ready_o = (state_q == S_ACC);
  assign acc         = smp_valid_i && smp_ready_o;

  // next state
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    res_d     = res_q;
    with_df_d = with_df_q;
    case (state_q)
      S_ACC: begin
        if (acc && smp_last_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        with_df_d = 1'b0;
        if (stat_i.small_grp) begin
          res_d   = RES_SMALL;
          state_d = S_FINISH;
        end else begin
          step_d  = ST_NQ0;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_RUN;
      end
      S_RUN: begin
        if (stat_i.unit_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        case (step_q)
          ST_V1: begin
            state_d = S_VCHK;
          end
          ST_T: begin
            res_d = RES_OK;
            if (stat_i.report_df) begin
              with_df_d = 1'b1;
              step_d    = ST_NORM;
              state_d   = S_LOAD;
            end else begin
              state_d = S_FINISH;
            end
          end
          ST_DF: begin
            res_d   = RES_OK;
            state_d = S_FINISH;
          end
          default: begin
            step_d  = step_e'(step_q + 1'b1);
            state_d = S_LOAD;
          end
        endcase
      end
      S_VCHK: begin
        if (stat_i.v_zero) begin
          res_d   = RES_ZERO;
          state_d = S_FINISH;
        end else begin
          step_d  = ST_SQRT;
          state_d = S_LOAD;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!stat_i.out_full) begin
          state_d = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    cmd_o.acc     = acc;
    cmd_o.load    = (state_q == S_LOAD);
    cmd_o.run     = (state_q == S_RUN);
    cmd_o.store   = (state_q == S_STORE);
    cmd_o.publish = (state_q == S_FINISH) && !stat_i.out_full;
    cmd_o.step    = step_q;
    cmd_o.res     = res_q;
    cmd_o.with_df = with_df_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_ACC;
      step_q    <= ST_NQ0;
      res_q     <= RES_OK;
      with_df_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      res_q     <= res_d;
      with_df_q <= with_df_d;
    end
  end

  `WTS_ASSERT(a_last_starts_row, (smp_valid_i && smp_ready_o && smp_last_i) |=> state_q == S_CHECK, "last sample did not start the row result")
  `WTS_ASSERT(a_finish_fills, (state_q == S_FINISH && !stat_i.out_full) |=> (state_q == S_ACC) && stat_i.out_full, "finish did not load the result register")
endmodule

// File: design/wts_dpath.sv
// ----------------------------------------------------------------------------
// wts_dpath
// Datapath: per-group accumulators, bit-serial multiplier, divider,
// square root, normaliser and the result register.
// ----------------------------------------------------------------------------
`include "welch_t_statistic_macros.svh"

module wts_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic signed [wts_pkg::SMP_W-1:0] smp_value_i,
  input  logic                          smp_group_i,
  input  wts_pkg::wts_cmd_t             cmd_i,
  output wts_pkg::wts_stat_t            stat_o,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic signed [wts_pkg::T_W-1:0] t_stat_o,
  output logic [wts_pkg::DF_W-1:0]      welch_df_o,
  output logic [wts_pkg::STATUS_W-1:0]  status_o
);
  import wts_pkg::*;

  function automatic unit_e unit_of(input step_e s);
    case (s)
      ST_V0, ST_V1, ST_T, ST_DF: unit_of = U_DIV;
      ST_SQRT:                   unit_of = U_SQRT;
      ST_NORM:                   unit_of = U_NORM;
      default:                   unit_of = U_MUL;
    endcase
  endfunction

  // accumulators and configuration
  logic                    report_df_q;
  logic [CNT_W-1:0]        cnt0_q, cnt1_q;
  logic signed [SUM_W-1:0] sum0_q, sum1_q;
  logic [SQ_W-1:0]         sq0_q, sq1_q;
  logic [CNT_W:0]          cnt_sum;
  logic                    room;
  logic signed [2*SMP_W-1:0] val_sq;
  logic [SQ_W-1:0]         sq_ext;
  logic signed [SUM_W-1:0] val_ext;

  // work registers
  logic [WW-1:0] x0_q, x1_q, y0_q, v0_q, v1_q, vs_q, ra_q, rb_q;
  logic [HW-1:0] se_q, num_q;
  logic [T_W-1:0]  t_q;
  logic [DF_W-1:0] df_q;

  // serial units
  logic [WW-1:0]  m_a_q, m_p_q;
  logic [HW-1:0]  m_b_q;
  logic [HW+2:0]  sq_rem_q;
  logic [HW-1:0]  sq_root_q;
  logic [WW-1:0]  sq_x_q;
  logic [SQR_CNT_W-1:0] sq_cnt_q;
  logic [HW+2:0]  sq_sh, sq_trial;

  // operand selection
  logic [WW-1:0] op_a, div_num, div_den, div_quo, ab_sum;
  logic [HW-1:0] op_b;
  logic [SUM_W-1:0] abs0, abs1;
  logic [WW-1:0] n0, n1, m0, m1;
  logic [HW-1:0] num_mag, p0, p1, sp0, sp1;
  logic [T_W-1:0]  t_sat;
  logic [DF_W-1:0] df_sat;
  unit_e         unit;
  logic          unit_done, div_done, div_start, run_step;

  // result register
  logic                res_valid_q;
  logic [T_W-1:0]      t_out_q;
  logic [DF_W-1:0]     df_out_q;
  logic [STATUS_W-1:0] st_out_q;

  assign cnt_sum = {1'b0, cnt0_q} + {1'b0, cnt1_q};
  assign room    = (cnt_sum < (CNT_W+1)'(MAX_SAMPLES));
  assign val_sq  = smp_value_i * smp_value_i;
  assign sq_ext  = {{(SQ_W-VAL_SQ_W){1'b0}}, val_sq[VAL_SQ_W-1:0]};
  assign val_ext = {{(SUM_W-SMP_W){smp_value_i[SMP_W-1]}}, smp_value_i};

  assign abs0   = sum0_q[SUM_W-1] ? SUM_W'(-sum0_q) : SUM_W'(sum0_q);
  assign abs1   = sum1_q[SUM_W-1] ? SUM_W'(-sum1_q) : SUM_W'(sum1_q);
  assign n0     = WW'(cnt0_q);
  assign n1     = WW'(cnt1_q);
  assign m0     = WW'(cnt0_q - 1'b1);
  assign m1     = WW'(cnt1_q - 1'b1);
  assign ab_sum = ra_q + rb_q;
  assign num_mag = num_q[HW-1] ? -num_q : num_q;

  assign unit = unit_of(cmd_i.step);

  // operands per step
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    div_num = '0;
    div_den = y0_q;
    case (cmd_i.step)
      ST_NQ0:  begin op_a = WW'(sq0_q); op_b = n0[HW-1:0]; end
      ST_SS0:  begin op_a = WW'(abs0);  op_b = HW'(abs0);  end
      ST_DA0:  begin op_a = n0;         op_b = n0[HW-1:0]; end
      ST_DB0:  begin op_a = y0_q;       op_b = m0[HW-1:0]; end
      ST_V0:   begin div_num = x0_q << V_SHIFT; end
      ST_NQ1:  begin op_a = WW'(sq1_q); op_b = n1[HW-1:0]; end
      ST_SS1:  begin op_a = WW'(abs1);  op_b = HW'(abs1);  end
      ST_DA1:  begin op_a = n1;         op_b = n1[HW-1:0]; end
      ST_DB1:  begin op_a = y0_q;       op_b = m1[HW-1:0]; end
      ST_V1:   begin div_num = x0_q << V_SHIFT; end
      ST_P1:   begin op_a = WW'(abs1);  op_b = n0[HW-1:0]; end
      ST_P0:   begin op_a = WW'(abs0);  op_b = n1[HW-1:0]; end
      ST_NN:   begin op_a = n0;         op_b = n1[HW-1:0]; end
      ST_NSE:  begin op_a = y0_q;       op_b = se_q;       end
      ST_T:    begin div_num = WW'(num_mag) << T_SHIFT; end
      ST_AB2:  begin op_a = ab_sum;     op_b = ab_sum[HW-1:0]; end
      ST_MM:   begin op_a = m0;         op_b = m1[HW-1:0]; end
      ST_NM:   begin op_a = x0_q;       op_b = y0_q[HW-1:0]; end
      ST_A2:   begin op_a = ra_q;       op_b = ra_q[HW-1:0]; end
      ST_A2M:  begin op_a = y0_q;       op_b = m1[HW-1:0]; end
      ST_B2:   begin op_a = rb_q;       op_b = rb_q[HW-1:0]; end
      ST_B2M:  begin op_a = x1_q;       op_b = m0[HW-1:0]; end
      ST_DF:   begin div_num = x0_q << DF_SHIFT; end
      default: begin op_a = '0; end
    endcase
  end

  assign div_start = cmd_i.load && (unit == U_DIV);

  wts_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    case (unit)
      U_MUL:   unit_done = (m_b_q == '0);
      U_DIV:   unit_done = div_done;
      U_SQRT:  unit_done = (sq_cnt_q == '0);
      U_NORM:  unit_done = (x1_q[WW-1:NORM_BITS] == '0);
      default: unit_done = 1'b1;
    endcase
  end

  assign run_step = cmd_i.run && !unit_done;

  // shift-and-add multiplier: one bit of B per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (unit == U_MUL)) begin
      m_a_q <= op_a;
      m_b_q <= op_b;
      m_p_q <= '0;
    end else if (run_step && (unit == U_MUL)) begin
      if (m_b_q[0]) begin
        m_p_q <= m_p_q + m_a_q;
      end
      m_a_q <= m_a_q << 1;
      m_b_q <= m_b_q >> 1;
    end
  end

  // digit-by-digit square root, two radicand bits per cycle
  assign sq_sh    = {sq_rem_q[HW:0], sq_x_q[WW-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (unit == U_SQRT)) begin
      sq_x_q    <= vs_q;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= SQR_CNT_W'(HW);
    end else if (run_step && (unit == U_SQRT)) begin
      if (sq_sh >= sq_trial) begin
        sq_rem_q  <= sq_sh - sq_trial;
        sq_root_q <= {sq_root_q[HW-2:0], 1'b1};
      end else begin
        sq_rem_q  <= sq_sh;
        sq_root_q <= {sq_root_q[HW-2:0], 1'b0};
      end
      sq_x_q   <= sq_x_q << 2;
      sq_cnt_q <= sq_cnt_q - 1'b1;
    end
  end

  // saturation of the quotients
  always_comb begin
    if (num_q[HW-1]) begin
      t_sat = (|div_quo[WW-1:T_W-1]) ? {1'b1, {(T_W-1){1'b0}}} : -div_quo[T_W-1:0];
    end else begin
      t_sat = (|div_quo[WW-1:T_W-1]) ? {1'b0, {(T_W-1){1'b1}}} : div_quo[T_W-1:0];
    end
    df_sat = (|div_quo[WW-1:DF_W]) ? '1 : div_quo[DF_W-1:0];
  end

  assign p1  = x1_q[HW-1:0];
  assign p0  = m_p_q[HW-1:0];
  assign sp1 = sum1_q[SUM_W-1] ? -p1 : p1;
  assign sp0 = sum0_q[SUM_W-1] ? -p0 : p0;

  // work registers: normaliser shift and step write-back
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (unit == U_NORM)) begin
      ra_q <= v0_q;
      rb_q <= v1_q;
      x1_q <= vs_q;
    end else if (run_step && (unit == U_NORM)) begin
      ra_q <= ra_q >> 1;
      rb_q <= rb_q >> 1;
      x1_q <= x1_q >> 1;
    end else if (cmd_i.store) begin
      case (cmd_i.step)
        ST_NQ0, ST_NQ1, ST_AB2, ST_NM: x0_q <= m_p_q;
        ST_SS0, ST_SS1: x0_q <= (x0_q >= m_p_q) ? (x0_q - m_p_q) : '0;
        ST_DA0, ST_DB0, ST_DA1, ST_DB1, ST_NN, ST_NSE, ST_MM, ST_A2, ST_A2M: y0_q <= m_p_q;
        ST_V0:   v0_q <= div_quo;
        ST_V1: begin
          v1_q <= div_quo;
          vs_q <= v0_q + div_quo;
        end
        ST_SQRT: se_q <= sq_root_q;
        ST_P1, ST_B2: x1_q <= m_p_q;
        ST_P0:   num_q <= sp1 - sp0;
        ST_T:    t_q <= t_sat;
        ST_B2M:  y0_q <= y0_q + m_p_q;
        ST_DF:   df_q <= df_sat;
        default: x0_q <= x0_q;
      endcase
    end
  end

  // accumulators, configuration and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_df_q <= 1'b1;
      cnt0_q      <= '0;
      cnt1_q      <= '0;
      sum0_q      <= '0;
      sum1_q      <= '0;
      sq0_q       <= '0;
      sq1_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        report_df_q <= cfg_wdata_i;
      end
      if (cmd_i.publish) begin
        cnt0_q      <= '0;
        cnt1_q      <= '0;
        sum0_q      <= '0;
        sum1_q      <= '0;
        sq0_q       <= '0;
        sq1_q       <= '0;
        res_valid_q <= 1'b1;
      end else begin
        if (res_valid_q && res_ready_i) begin
          res_valid_q <= 1'b0;
        end
        if (cmd_i.acc && room) begin
          if (smp_group_i) begin
            cnt1_q <= cnt1_q + 1'b1;
            sum1_q <= sum1_q + val_ext;
            sq1_q  <= sq1_q + sq_ext;
          end else begin
            cnt0_q <= cnt0_q + 1'b1;
            sum0_q <= sum0_q + val_ext;
            sq0_q  <= sq0_q + sq_ext;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      st_out_q <= cmd_i.res;
      case (cmd_i.res)
        RES_OK: begin
          t_out_q  <= t_q;
          df_out_q <= cmd_i.with_df ? df_q : '0;
        end
        default: begin
          t_out_q  <= '0;
          df_out_q <= '0;
        end
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign t_stat_o    = t_out_q;
  assign welch_df_o  = df_out_q;
  assign status_o    = st_out_q;

  always_comb begin
    stat_o           = '0;
    stat_o.small_grp = (cnt0_q < CNT_W'(2)) || (cnt1_q < CNT_W'(2));
    stat_o.v_zero    = (vs_q == '0);
    stat_o.unit_done = unit_done;
    stat_o.out_full  = res_valid_q;
    stat_o.report_df = report_df_q;
  end

  `WTS_ASSERT(a_row_cleared, $rose(res_valid_q) |-> cnt_sum == '0, "accumulators not cleared with the result")
  `WTS_ASSERT(a_count_cap, cnt_sum <= (CNT_W+1)'(MAX_SAMPLES), "row count beyond sample limit")
  `WTS_ASSERT_RST(a_reset_empty, !rst_ni |-> !res_valid_q, "result valid during reset")
endmodule

// File: design/welch_t_statistic.sv
// ----------------------------------------------------------------------------
// welch_t_statistic
// Streams the samples of one row into per-group sums and, on the last
// sample, returns the Welch t statistic and degrees of freedom.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  smp_i     in    valid / ready      sample_value, group_flag, last_sample
//  res_o     out   valid / ready      t_stat, welch_df, status
//  cfg       in    cfg_we_i           cfg_wdata_i (report_df)
//
//  Samples transfer at one per cycle while the block collects a row.
//  After the last sample the row result is worked out by the bit-serial
//  multiplier, the 128-step divider (three divisions, four with degrees
//  of freedom) and the 64-step square root.
//  Reset clears the accumulators, empties the result register and sets
//  report_df to 1. A waiting result does not block smp_i; the next row's
//  result holds, with ready low, until res_o has transferred the old one.
// ----------------------------------------------------------------------------
module welch_t_statistic (
  input logic      clk_i,
  input logic      rst_ni,
  wts_smp_if.sink  smp_i,
  wts_res_if.source res_o,
  input logic      cfg_we_i,
  input logic      cfg_wdata_i
);
  import wts_pkg::*;

  wts_cmd_t  cmd;
  wts_stat_t stat;
  logic      smp_ready;

  // controller: sample intake and the step sequence of the row result
  wts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp_i.valid),
    .smp_last_i  (smp_i.last_sample),
    .smp_ready_o (smp_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  assign smp_i.ready = smp_ready;

  // datapath: accumulators, arithmetic units and result register
  wts_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .smp_value_i (smp_i.sample_value),
    .smp_group_i (smp_i.group_flag),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .t_stat_o    (res_o.t_stat),
    .welch_df_o  (res_o.welch_df),
    .status_o    (res_o.status)
  );
endmodule

// File: bench/wts_checker.sv
// ----------------------------------------------------------------------------
// wts_checker
// Watches the sample, result and register ports of the Welch t statistic
// block. It keeps its own copy of the row state, works out each row result
// and compares every result transfer with the oldest expected one.
// ----------------------------------------------------------------------------
module wts_checker
  import wts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wts_smp_if          smp,
  wts_res_if          res,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned rows_waiting_o,
  output int unsigned rows_checked_o
);

  typedef struct packed {
    logic [T_W-1:0]  t_stat;
    logic [DF_W-1:0] welch_df;
    res_e            status;
  } row_result_t;

  typedef logic [255:0] big_t;

  row_result_t               row_results_q[$];
  logic                      df_on;
  logic [CNT_W-1:0]          cnt0, cnt1;
  logic signed [SUM_W-1:0]   sum0, sum1;
  logic [SQ_W-1:0]           sq0, sq1;
  int unsigned               fails, checked;

  // Variance of one group's mean, units of 2^-24
  function automatic big_t mean_var(int unsigned n, logic signed [SUM_W-1:0] s,
                                    logic [SQ_W-1:0] q);
    longint sl;
    big_t   mag, nq, s2, d, den;
    sl  = s;
    mag = big_t'(sl < 0 ? -sl : sl);
    nq  = big_t'(n) * big_t'(q);
    s2  = mag * mag;
    d   = (nq < s2) ? '0 : nq - s2;
    den = big_t'(n) * big_t'(n) * big_t'(n - 1);
    return (d << V_SHIFT) / den;
  endfunction

  function automatic big_t int_sqrt(big_t x);
    big_t r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (big_t'(1) << i);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // Result of the row held in the mirror state
  function automatic row_result_t row_outcome();
    row_result_t r;
    int unsigned n0, n1, bl, sh;
    big_t        v0, v1, v, se, mag, qv, nm, dn, dfv;
    longint      num;
    logic [63:0] a, b, ab, m0, m1;
    r  = '{t_stat: '0, welch_df: '0, status: RES_OK};
    n0 = cnt0;
    n1 = cnt1;
    if (n0 < 2 || n1 < 2) begin
      r.status = RES_SMALL;
      return r;
    end
    v0 = mean_var(n0, sum0, sq0);
    v1 = mean_var(n1, sum1, sq1);
    v  = v0 + v1;
    if (v == 0) begin
      r.status = RES_ZERO;
      return r;
    end
    se  = int_sqrt(v);
    num = longint'(sum1) * longint'(n0) - longint'(sum0) * longint'(n1);
    mag = big_t'(num < 0 ? -num : num);
    qv  = (mag << T_SHIFT) / (big_t'(n0) * big_t'(n1) * se);
    if (num < 0) begin
      if (qv >= big_t'(64'h8000_0000)) r.t_stat = 32'h8000_0000;
      else r.t_stat = -qv[31:0];
    end else begin
      r.t_stat = (qv > big_t'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : qv[31:0];
    end
    if (df_on) begin
      bl = 0;
      for (int i = 0; i < 256; i++) if (v[i]) bl = i + 1;
      sh  = (bl > NORM_BITS) ? bl - NORM_BITS : 0;
      a   = 64'(v0 >> sh);
      b   = 64'(v1 >> sh);
      m0  = n0 - 1;
      m1  = n1 - 1;
      ab  = (a + b) * (a + b);
      nm  = (big_t'(ab) * big_t'(m0 * m1)) << DF_SHIFT;
      dn  = big_t'(a * a) * big_t'(m1) + big_t'(b * b) * big_t'(m0);
      dfv = (dn == 0) ? '0 : nm / dn;
      r.welch_df = (dfv > big_t'(26'h3FF_FFFF)) ? 26'h3FF_FFFF : dfv[DF_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    row_result_t want;
    longint      sv;
    if (!rst_ni) begin
      row_results_q.delete();
      df_on = 1'b1;
      {cnt0, cnt1, sum0, sum1, sq0, sq1} = '0;
      fails   = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) df_on = cfg_wdata_i;
      if (smp.valid && smp.ready) begin
        if (cnt0 + cnt1 < MAX_SAMPLES) begin
          sv = smp.sample_value;
          if (smp.group_flag) begin
            cnt1++; sum1 += smp.sample_value; sq1 += SQ_W'(sv * sv);
          end else begin
            cnt0++; sum0 += smp.sample_value; sq0 += SQ_W'(sv * sv);
          end
        end
        if (smp.last_sample) begin
          row_results_q.push_back(row_outcome());
          {cnt0, cnt1, sum0, sum1, sq0, sq1} = '0;
        end
      end
      if (res.valid && res.ready) begin
        if (row_results_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result t=%h df=%h status=%0d",
                                    res.t_stat, res.welch_df, res.status);
        end else begin
          want = row_results_q.pop_front();
          checked++;
          if (res.t_stat !== want.t_stat || res.welch_df !== want.welch_df ||
              res.status !== want.status) begin
            fails++;
            if (fails <= 10)
              $display("row %0d mismatch: t %h/%h df %h/%h status %0d/%0d (exp/got)",
                       checked, want.t_stat, res.t_stat, want.welch_df,
                       res.welch_df, want.status, res.status);
          end
        end
      end
    end
    fail_count_o   <= fails;
    rows_waiting_o <= row_results_q.size();
    rows_checked_o <= checked;
  end

endmodule

// File: bench/welch_t_statistic_tb.sv
// ----------------------------------------------------------------------------
// welch_t_statistic_tb
// Streams rows of grouped samples into the Welch t statistic block under
// random source and sink gaps and both df settings; a checker beside the
// block predicts every row result and compares it.
// ----------------------------------------------------------------------------
module welch_t_statistic_tb;
  import wts_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned LONG_HOLD  = 3000;
  localparam int unsigned DRAIN      = 1300;  // one row computation and margin
  localparam int VMAX = 8388607;
  localparam int VMIN = -8388608;

  // row flavours
  typedef enum int {ROW_RANDOM, ROW_FLAT, ROW_ONE_GROUP, ROW_FAR} row_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  int unsigned fail_count, rows_waiting, rows_checked;
  int unsigned items_sent, idle_cycles;
  bit          burst;        // no idling on either side while set
  bit          hold_req;     // ask the sink for one long hold-off

  wts_smp_if smp ();
  wts_res_if res ();

  welch_t_statistic dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_i       (smp),
    .res_o       (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wts_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .smp            (smp),
    .res            (res),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .fail_count_o   (fail_count),
    .rows_waiting_o (rows_waiting),
    .rows_checked_o (rows_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hold every input at a known value from time zero
  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    smp.valid        = 1'b0;
    smp.sample_value = '0;
    smp.group_flag   = 1'b0;
    smp.last_sample  = 1'b0;
    res.ready        = 1'b0;
    burst            = 1'b0;
    hold_req         = 1'b0;
  end

  // Watchdog: drop out when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: random gaps per transfer, one long hold-off on request
  initial begin
    int unsigned gap;
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res.valid && res.ready)) @(posedge clk_i);
    end
  end

  // Offer one sample and hold it until it transfers
  task automatic push(int v, bit g, bit l);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid        <= 1'b1;
    smp.sample_value <= v[SMP_W-1:0];
    smp.group_flag   <= g;
    smp.last_sample  <= l;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic int clip(int v);
    return (v > VMAX) ? VMAX : (v < VMIN) ? VMIN : v;
  endfunction

  // Send one row of n samples shaped by kind
  task automatic send_row(int unsigned n, row_kind_e kind);
    int  base[2], spread, v;
    bit  g, lone_grp, full_rng;
    full_rng = ($urandom_range(0, 3) == 0);
    lone_grp = $urandom_range(0, 1);
    spread   = 1 << $urandom_range(0, 20);
    for (int k = 0; k < 2; k++) base[k] = clip(int'($urandom_range(0, 16777215)) - 8388608);
    if (kind == ROW_FAR) begin
      base[0] = VMIN + 2;
      base[1] = VMAX - 2;
      spread  = 2;
    end
    for (int unsigned i = 0; i < n; i++) begin
      g = (kind == ROW_ONE_GROUP) ? lone_grp : $urandom_range(0, 1);
      // keep both groups present in rows of four samples or more so results are mostly valid
      if (kind != ROW_ONE_GROUP && n >= 4 && i < 4) g = i[0];
      case (kind)
        ROW_FLAT: v = base[g];
        ROW_FAR:  v = base[g] + int'($urandom_range(0, 2)) - 1;
        default:  v = full_rng ? int'($urandom_range(0, 16777215)) - 8388608
                               : clip(base[g] + int'($urandom_range(0, spread)) - spread / 2);
      endcase
      push(v, g, i == n - 1);
    end
  endtask

  // Drain all rows, let the block settle, then write report_df
  task automatic set_report_df(bit on);
    smp.valid <= 1'b0;
    @(posedge clk_i);
    while (rows_waiting != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned n, pick, phase;
    items_sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_report_df(1'b1);

    // Directed: extreme values in both groups, a lone sample, a flat row,
    // a saturating row, a row with one group only and a zero-variance row
    push(VMAX, 1'b0, 1'b0);
    push(VMIN, 1'b0, 1'b0);
    push(VMAX, 1'b1, 1'b0);
    push(VMIN, 1'b1, 1'b0);
    push(0,    1'b1, 1'b1);
    push(VMIN, 1'b1, 1'b1);
    send_row(4, ROW_FLAT);
    send_row(6, ROW_FAR);
    send_row(3, ROW_ONE_GROUP);
    push(VMIN, 1'b0, 1'b0);
    push(VMIN, 1'b0, 1'b0);
    push(VMAX, 1'b1, 1'b0);
    push(VMAX, 1'b1, 1'b1);
    set_report_df(1'b0);
    send_row(4, ROW_FAR);

    // Random phases, alternating the df setting
    phase = 0;
    while (items_sent < 2000) begin
      set_report_df(phase[0]);
      burst = (phase % 3 == 2);
      if (phase == 2) hold_req = 1'b1;  // sink stalls while rows keep coming
      for (int r = 0; r < 30; r++) begin
        pick = $urandom_range(0, 99);
        n = $urandom_range(2, 16);
        if (pick < 3) send_row(1, ROW_RANDOM);
        else if (pick < 8) send_row(n, ROW_FLAT);
        else if (pick < 13) send_row(n, ROW_FAR);
        else if (pick < 18) send_row(n, ROW_ONE_GROUP);
        else send_row(n, ROW_RANDOM);
      end
      // a few rows overrun the sample limit
      if (phase == 1 || phase == 4) send_row(MAX_SAMPLES + 6, ROW_RANDOM);
      phase++;
    end
    burst = 1'b0;
    smp.valid <= 1'b0;

    @(posedge clk_i);
    while (rows_waiting != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    $display("Sent %0d samples over %0d phases; %0d row results checked, %0d failures.",
             items_sent, phase, rows_checked, fail_count);
    if (fail_count == 0 && rows_waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
